/* rtl/rc4_pkg.sv */
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int BYTE_W            = 8;
    localparam int SBOX_DEPTH        = 256;
    localparam int KEY_BYTES_MAX_DEF = 256;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KS_FILL,
        ST_KS_RD_K,
        ST_KS_RD_J,
        ST_KS_WR_K,
        ST_KS_WR_J,
        ST_KS_DONE,
        ST_GEN_RD_I,
        ST_GEN_RD_J,
        ST_GEN_WR_I,
        ST_GEN_WR_J
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FILL,
        OP_KEY_LOAD,
        OP_KS_RD_K,
        OP_KS_RD_J,
        OP_KS_WR_K,
        OP_KS_WR_J,
        OP_KS_DONE,
        OP_GEN_RD_I,
        OP_GEN_RD_J,
        OP_GEN_WR_I,
        OP_GEN_WR_J
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_last;
    } dp_stat_t;

endpackage

/* rtl/rc4_ram.sv */
`timescale 1ns / 1ps

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rc4_ctrl.sv */
`timescale 1ns / 1ps

module rc4_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_ready,
    output rc4_pkg::dp_cmd_t  cmd,
    input  rc4_pkg::dp_stat_t stat
);

    import rc4_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg & ~out_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_FILL;
                if (stat.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind == KIND_DATA)
                    begin
                        cmd.op     = OP_GEN_RD_I;
                        state_next = ST_GEN_RD_I;
                    end
                    else
                    begin
                        cmd.op = OP_KEY_LOAD;
                        if (last)
                        begin
                            state_next = ST_KS_FILL;
                        end
                    end
                end
            end
            ST_KS_FILL:
            begin
                cmd.op = OP_FILL;
                if (stat.cnt_last)
                begin
                    state_next = ST_KS_RD_K;
                end
            end
            ST_KS_RD_K:
            begin
                cmd.op     = OP_KS_RD_K;
                state_next = ST_KS_RD_J;
            end
            ST_KS_RD_J:
            begin
                cmd.op     = OP_KS_RD_J;
                state_next = ST_KS_WR_K;
            end
            ST_KS_WR_K:
            begin
                cmd.op     = OP_KS_WR_K;
                state_next = ST_KS_WR_J;
            end
            ST_KS_WR_J:
            begin
                cmd.op     = OP_KS_WR_J;
                state_next = stat.cnt_last ? ST_KS_DONE : ST_KS_RD_K;
            end
            ST_KS_DONE:
            begin
                cmd.op     = OP_KS_DONE;
                state_next = ST_IDLE;
            end
            // the read of S[i] was issued on acceptance
            ST_GEN_RD_I:
            begin
                cmd.op     = OP_GEN_RD_J;
                state_next = ST_GEN_RD_J;
            end
            ST_GEN_RD_J:
            begin
                cmd.op     = OP_GEN_WR_I;
                state_next = ST_GEN_WR_I;
            end
            ST_GEN_WR_I:
            begin
                state_next = ST_GEN_WR_J;
            end
            ST_GEN_WR_J:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_GEN_WR_J;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/rc4_datapath.sv */
`timescale 1ns / 1ps

module rc4_datapath #(
    parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rc4_pkg::dp_cmd_t  cmd,
    output rc4_pkg::dp_stat_t stat,
    input  logic [7:0]        value,
    input  logic              last,
    output logic [7:0]        cipher_byte,
    output logic [7:0]        keystream_byte,
    output logic              end_of_message
);

    import rc4_pkg::*;

    localparam int KA  = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
    localparam int KCW = $clog2(KEY_BYTES_MAX + 1);
    localparam int SA  = $clog2(SBOX_DEPTH);

    // control state
    logic [SA-1:0]  cnt_reg,  cnt_next;
    logic [SA-1:0]  i_reg,    i_next;
    logic [SA-1:0]  j_reg,    j_next;
    logic [KCW-1:0] kcnt_reg, kcnt_next;
    logic [KA-1:0]  kidx_reg, kidx_next;

    // payload
    byte_t         si_reg, sj_reg;
    logic [SA-1:0] idx_reg;
    byte_t         value_reg;
    logic          last_reg;
    byte_t         cipher_reg, ks_reg;
    logic          eom_reg;

    // memory ports
    logic          s_we, s_re;
    logic [SA-1:0] s_waddr, s_raddr;
    byte_t         s_wdata, s_rdata;
    logic          k_we, k_re;
    logic [KA-1:0] k_waddr;
    byte_t         k_rdata;

    logic [KCW-1:0] key_len;
    logic           kidx_wrap;
    byte_t          ks;

    rc4_ram #(.WIDTH(BYTE_W), .DEPTH(SBOX_DEPTH)) u_sbox (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_BYTES_MAX), .AW(KA)) u_key (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (value),
        .re    (k_re),
        .raddr (kidx_reg),
        .rdata (k_rdata)
    );

    // an empty key store behaves as one key byte
    assign key_len   = (kcnt_reg == '0) ? KCW'(1) : kcnt_reg;
    assign kidx_wrap = ((KCW + 1)'(kidx_reg) + (KCW + 1)'(1)) == (KCW + 1)'(key_len);
    assign k_waddr   = kcnt_reg[KA-1:0];

    // swap of S[i] and S[j] may land on the keystream index
    always_comb
    begin
        if (idx_reg == j_reg)
        begin
            ks = si_reg;
        end
        else if (idx_reg == i_reg)
        begin
            ks = sj_reg;
        end
        else
        begin
            ks = s_rdata;
        end
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        kcnt_next = kcnt_reg;
        kidx_next = kidx_reg;
        s_we      = 1'b0;
        s_waddr   = cnt_reg;
        s_wdata   = s_rdata;
        s_re      = 1'b0;
        s_raddr   = cnt_reg;
        k_we      = 1'b0;
        k_re      = 1'b0;
        case (cmd.op)
            OP_FILL:
            begin
                s_we     = 1'b1;
                s_wdata  = BYTE_W'(cnt_reg);
                cnt_next = cnt_reg + SA'(1);
                // the swap walk starts from j = 0
                j_next   = '0;
            end
            OP_KEY_LOAD:
            begin
                // drop key bytes beyond the store
                if (kcnt_reg < KCW'(KEY_BYTES_MAX))
                begin
                    k_we      = 1'b1;
                    kcnt_next = kcnt_reg + KCW'(1);
                end
            end
            OP_KS_RD_K:
            begin
                s_re = 1'b1;
                k_re = 1'b1;
            end
            OP_KS_RD_J:
            begin
                j_next  = j_reg + k_rdata + s_rdata;
                s_re    = 1'b1;
                s_raddr = j_next;
            end
            OP_KS_WR_K:
            begin
                s_we = 1'b1;
            end
            OP_KS_WR_J:
            begin
                s_we      = 1'b1;
                s_waddr   = j_reg;
                s_wdata   = si_reg;
                cnt_next  = cnt_reg + SA'(1);
                kidx_next = kidx_wrap ? '0 : kidx_reg + KA'(1);
            end
            OP_KS_DONE:
            begin
                i_next    = '0;
                j_next    = '0;
                kcnt_next = '0;
                kidx_next = '0;
            end
            OP_GEN_RD_I:
            begin
                i_next  = i_reg + SA'(1);
                s_re    = 1'b1;
                s_raddr = i_next;
            end
            OP_GEN_RD_J:
            begin
                j_next  = j_reg + s_rdata;
                s_re    = 1'b1;
                s_raddr = j_next;
            end
            OP_GEN_WR_I:
            begin
                s_we    = 1'b1;
                s_waddr = i_reg;
                s_re    = 1'b1;
                s_raddr = si_reg + s_rdata;
            end
            OP_GEN_WR_J:
            begin
                s_we    = 1'b1;
                s_waddr = j_reg;
                s_wdata = si_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            kcnt_reg <= '0;
            kidx_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            kcnt_reg <= kcnt_next;
            kidx_reg <= kidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_KS_RD_J, OP_GEN_RD_J:
            begin
                si_reg <= s_rdata;
            end
            OP_GEN_RD_I:
            begin
                value_reg <= value;
                last_reg  <= last;
            end
            OP_GEN_WR_I:
            begin
                sj_reg  <= s_rdata;
                idx_reg <= si_reg + s_rdata;
            end
            OP_GEN_WR_J:
            begin
                cipher_reg <= value_reg ^ ks;
                ks_reg     <= ks;
                eom_reg    <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.cnt_last  = (cnt_reg == SA'(SBOX_DEPTH - 1));
    assign cipher_byte    = cipher_reg;
    assign keystream_byte = ks_reg;
    assign end_of_message = eom_reg;

endmodule

/* rtl/rc4_stream_cipher.sv */
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// input    in_valid / in_ready   kind, value, last
// output   out_valid / out_ready cipher_byte, keystream_byte, end_of_message
//
// A key byte is taken on acceptance. A data byte runs read S[i], read S[j],
// write S[i] with keystream read, wait for the keystream word, write S[j], all
// through the single S-box RAM. The last key byte adds an identity refill,
// 256 schedule steps (read S[k] and the key byte, read S[j], write S[k], write
// S[j]) and a clear of i, j and the key count.
// After reset an identity fill of the S-box runs before the first transaction.
// A data byte waits in its last state while the previous result is not taken.

module rc4_stream_cipher #(
    parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] value,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] cipher_byte,
    output logic [7:0] keystream_byte,
    output logic       end_of_message
);

    import rc4_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rc4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    rc4_datapath #(.KEY_BYTES_MAX(KEY_BYTES_MAX)) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .value          (value),
        .last           (last),
        .cipher_byte    (cipher_byte),
        .keystream_byte (keystream_byte),
        .end_of_message (end_of_message)
    );

endmodule

/* tb/rc4_keystream_checker.sv */
`timescale 1ns / 1ps

module rc4_keystream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       kind,
    input  logic [7:0] value,
    input  logic       last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] cipher_byte,
    input  logic [7:0] keystream_byte,
    input  logic       end_of_message,
    output int         fail_count,
    output int         pending,
    output int         checked
);

    import rc4_pkg::*;

    typedef struct packed {
        byte_t cipher;
        byte_t ks;
        logic  eom;
    } cipher_out_t;

    byte_t       sbox_m [SBOX_DEPTH];
    byte_t       key_m  [SBOX_DEPTH];
    int unsigned key_cnt;
    byte_t       gen_i;
    byte_t       gen_j;

    cipher_out_t expected_q [$];
    int          mismatches   = 0;
    int          results_seen = 0;

    task automatic swap_entries(input byte_t a, input byte_t b);
        byte_t t;
        t         = sbox_m[a];
        sbox_m[a] = sbox_m[b];
        sbox_m[b] = t;
    endtask

    task automatic clear_cipher_state();
        for (int k = 0; k < SBOX_DEPTH; k++)
        begin
            sbox_m[k] = byte_t'(k);
            key_m[k]  = '0;
        end
        key_cnt = 0;
        gen_i   = '0;
        gen_j   = '0;
    endtask

    // Identity fill, then the 256-step swap walk over the collected key.
    task automatic schedule_key();
        int unsigned n;
        byte_t       acc;
        n   = (key_cnt == 0) ? 1 : key_cnt;
        acc = '0;
        for (int k = 0; k < SBOX_DEPTH; k++)
            sbox_m[k] = byte_t'(k);
        for (int k = 0; k < SBOX_DEPTH; k++)
        begin
            acc = acc + key_m[k % n] + sbox_m[k];
            swap_entries(byte_t'(k), acc);
        end
        gen_i   = '0;
        gen_j   = '0;
        key_cnt = 0;
    endtask

    task automatic absorb_input(input logic k, input byte_t v, input logic l);
        cipher_out_t res;
        byte_t       idx;
        byte_t       ks;
        if (k == KIND_KEY)
        begin
            // drop key bytes once the store is full
            if (key_cnt < KEY_BYTES_MAX_DEF)
            begin
                key_m[key_cnt] = v;
                key_cnt++;
            end
            if (l)
                schedule_key();
        end
        else
        begin
            gen_i = gen_i + 8'd1;
            gen_j = gen_j + sbox_m[gen_i];
            swap_entries(gen_i, gen_j);
            idx        = sbox_m[gen_i] + sbox_m[gen_j];
            ks         = sbox_m[idx];
            res.cipher = v ^ ks;
            res.ks     = ks;
            res.eom    = l;
            expected_q.push_back(res);
        end
    endtask

    task automatic compare_output();
        cipher_out_t want;
        results_seen++;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result: cipher_byte %02h keystream_byte %02h end_of_message %0b",
                   cipher_byte, keystream_byte, end_of_message);
            mismatches++;
        end
        else
        begin
            want = expected_q.pop_front();
            if (cipher_byte !== want.cipher)
            begin
                $error("cipher_byte: expected %02h, got %02h", want.cipher, cipher_byte);
                mismatches++;
            end
            if (keystream_byte !== want.ks)
            begin
                $error("keystream_byte: expected %02h, got %02h", want.ks, keystream_byte);
                mismatches++;
            end
            if (end_of_message !== want.eom)
            begin
                $error("end_of_message: expected %0b, got %0b", want.eom, end_of_message);
                mismatches++;
            end
        end
    endtask

    // Results before inputs: a byte accepted at this edge cannot be answered at it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cipher_state();
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                compare_output();
            if (in_valid && in_ready)
                absorb_input(kind, value, last);
            pending    <= expected_q.size();
            checked    <= results_seen;
            fail_count <= mismatches;
        end
    end

endmodule

/* tb/rc4_stream_cipher_test.sv */
`timescale 1ns / 1ps

module rc4_stream_cipher_test;
    import rc4_pkg::*;

    localparam int   ITEM_TARGET  = 1900;
    localparam int   QUIET_LIMIT  = 6000;
    localparam int   DRAIN_CYCLES = 1400;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       kind      = 1'b0;
    logic [7:0] value     = 8'h00;
    logic       last      = 1'b0;
    logic       out_ready = 1'b0;
    logic       calm      = 1'b0;

    logic       in_ready;
    logic       out_valid;
    logic [7:0] cipher_byte;
    logic [7:0] keystream_byte;
    logic       end_of_message;

    int fail_count;
    int pending;
    int checked;
    int items_sent = 0;
    int schedules  = 0;
    int full_keys  = 0;
    int quiet      = 0;

    rc4_stream_cipher i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .value          (value),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cipher_byte    (cipher_byte),
        .keystream_byte (keystream_byte),
        .end_of_message (end_of_message)
    );

    rc4_keystream_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .value          (value),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cipher_byte    (cipher_byte),
        .keystream_byte (keystream_byte),
        .end_of_message (end_of_message),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 10);

    // End the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("rc4_stream_cipher test failed");
            $finish;
        end
    end

    // Hold valid high across back-to-back transactions; lower it only to idle.
    task automatic send_byte(input logic k, input byte_t v, input logic l);
        while (!calm && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        last     <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (k == KIND_KEY && l)
            schedules++;
    endtask

    task automatic load_key(input int len);
        for (int n = 0; n < len; n++)
            send_byte(KIND_KEY, byte_t'($urandom_range(255)), n == len - 1);
        if (len > KEY_BYTES_MAX_DEF)
            full_keys++;
    endtask

    task automatic send_message(input int len);
        for (int n = 0; n < len; n++)
            send_byte(KIND_DATA, byte_t'($urandom_range(255)), n == len - 1);
    endtask

    initial
    begin
        int pick;
        int len;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Keystream from the reset S-box, before any key.
        send_byte(KIND_DATA, 8'h00, 1'b0);
        send_byte(KIND_DATA, 8'hFF, 1'b0);
        send_byte(KIND_DATA, 8'hA5, 1'b1);
        // Pending key bytes must not disturb the running generator.
        send_byte(KIND_KEY,  8'h00, 1'b0);
        send_byte(KIND_DATA, 8'h5A, 1'b0);
        send_byte(KIND_KEY,  8'hFF, 1'b1);
        send_byte(KIND_DATA, 8'hFF, 1'b0);
        send_byte(KIND_DATA, 8'h00, 1'b1);
        // Single-byte keys at both extremes.
        send_byte(KIND_KEY,  8'h00, 1'b1);
        send_byte(KIND_DATA, 8'h3C, 1'b0);
        send_byte(KIND_DATA, 8'hC3, 1'b0);
        send_byte(KIND_DATA, 8'hFF, 1'b1);
        send_byte(KIND_KEY,  8'hFF, 1'b1);
        send_byte(KIND_DATA, 8'h00, 1'b0);
        send_byte(KIND_DATA, 8'h81, 1'b1);
        // Last flag on a data byte does not restart the stream.
        send_byte(KIND_DATA, 8'h7E, 1'b1);
        send_byte(KIND_DATA, 8'h01, 1'b0);

        // Exactly full store, then a key that overflows it.
        load_key(KEY_BYTES_MAX_DEF);
        send_message(8);
        load_key(KEY_BYTES_MAX_DEF + 4);
        send_message(8);

        while (items_sent < ITEM_TARGET)
        begin
            calm <= (items_sent >= 900 && items_sent < 1250);
            pick  = $urandom_range(99);
            if (pick < 55)
            begin
                if ($urandom_range(39) == 0)
                    len = $urandom_range(200, 270);
                else
                    len = $urandom_range(1, 16);
                load_key(len);
                send_message($urandom_range(1, 40));
            end
            else if (pick < 80)
                send_message($urandom_range(1, 24));
            else
            begin
                repeat ($urandom_range(1, 10))
                    send_byte(logic'($urandom_range(1)), byte_t'($urandom_range(255)),
                              $urandom_range(3) == 0);
            end
        end
        in_valid <= 1'b0;
        calm     <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // allow a trailing key schedule to finish
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes: %0d key schedules, %0d past a full key store.",
                 items_sent, schedules, full_keys);
        $display("Checked %0d cipher results against the predicted keystream.", checked);
        if (fail_count == 0)
            $display("rc4_stream_cipher test passed");
        else
            $display("rc4_stream_cipher test failed");
        $finish;
    end

endmodule
